/* rtl/msd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message stream deframer package
// Shared codes, table entry and result types for the deframer.
// ----------------------------------------------------------------------------
package msd_pkg;

	// Input transaction kinds.
	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// Reader phases.
	localparam logic [1:0] PH_ID   = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_EXT  = 2'd2;
	localparam logic [1:0] PH_BODY = 2'd3;

	// Result kinds.
	localparam logic [1:0] RK_HEADER = 2'd0;
	localparam logic [1:0] RK_BODY   = 2'd1;
	localparam logic [1:0] RK_ERROR  = 2'd2;

	// A 16-bit length of all ones announces a 32-bit extended length.
	localparam logic [15:0] LEN_ESCAPE = 16'hFFFF;

	localparam int DEFAULT_TABLE_SLOTS = 1024;

	// Result queue geometry (depth must be a power of two).
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic        known;
		logic        var_len;
		logic [15:0] len;
	} msd_entry_t;

	localparam int ENTRY_W = $bits(msd_entry_t);

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] message_id;
		logic [31:0] body_length;
		logic [7:0]  body_byte;
		logic        last_of_message;
	} msd_result_t;

	typedef struct packed {
		logic        valid;
		msd_result_t item;
	} msd_push_t;

endpackage

/* rtl/msd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel carrying stream bytes and id table writes.
// ----------------------------------------------------------------------------
interface msd_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         data_byte;
	logic [9:0]         table_slot;
	logic               slot_known;
	logic signed [16:0] slot_length;

	modport source (
		output valid, kind, data_byte, table_slot, slot_known, slot_length,
		input  ready
	);
	modport sink (
		input  valid, kind, data_byte, table_slot, slot_known, slot_length,
		output ready
	);
endinterface

/* rtl/msd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying header, body byte and error results.
// ----------------------------------------------------------------------------
interface msd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] message_id;
	logic [31:0] body_length;
	logic [7:0]  body_byte;
	logic        last_of_message;

	modport source (
		output valid, result_kind, message_id, body_length, body_byte, last_of_message,
		input  ready
	);
	modport sink (
		input  valid, result_kind, message_id, body_length, body_byte, last_of_message,
		output ready
	);
endinterface

/* rtl/msd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msd_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/msd_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small queue taking up to two results per cycle, in order, and giving one.
// ----------------------------------------------------------------------------
module msd_out_queue
	import msd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  msd_push_t           push_a,
	input  msd_push_t           push_b,
	input  logic                pop,
	output msd_result_t         head,
	output logic [QUEUE_CW-1:0] level
);

	msd_result_t         entries_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] level_q;
	logic [1:0]          n_push;
	msd_result_t         first_item;
	logic [QUEUE_PW-1:0] wr_ptr_next;

	assign n_push      = 2'(push_a.valid) + 2'(push_b.valid);
	assign first_item  = push_a.valid ? push_a.item : push_b.item;
	assign wr_ptr_next = wr_ptr_q + QUEUE_PW'(1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entries_q[wr_ptr_q] <= first_item;
		end
		if (n_push == 2'd2) begin
			entries_q[wr_ptr_next] <= push_b.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PW'(1);
			end
			level_q <= level_q + QUEUE_CW'(n_push) - QUEUE_CW'(pop);
		end
	end

	assign head  = entries_q[rd_ptr_q];
	assign level = level_q;

`ifndef SYNTH
	// Pushes never exceed the free space left after this cycle's pop.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(QUEUE_CW + 1)'(n_push) + (QUEUE_CW + 1)'(level_q)
			<= (QUEUE_CW + 1)'(QUEUE_DEPTH) + (QUEUE_CW + 1)'(pop))
		else $error("result queue overflow");
	// A pop is only requested while an entry is held.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> level_q != '0)
		else $error("result queue underflow");
`endif

endmodule

/* rtl/message_stream_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message stream deframer
// Splits a byte stream into id / length / body messages using a loaded table.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle while ready is high,
// whether a stream byte or an id table write, and gives at most one result
// per transaction. Straight after reset the id table is cleared by a pass
// over all TABLE_SLOTS entries, during which ready stays low. The table sits
// in a synchronous RAM: the lookup starts on the second id byte and its
// answer arrives in the next cycle, where the header or error result is
// formed alongside the processing of the following byte. Both results
// enter a four-entry result queue, so ready drops only when fewer than two
// queue entries are free; with a sink that takes a result every cycle the
// sustained rate is one transaction per cycle.
module message_stream_deframer
	import msd_pkg::*;
#(
	parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
	input logic     clk,
	input logic     arst_n,
	msd_in_if.sink  stream,
	msd_out_if.source result
);

	localparam int AW = $clog2(TABLE_SLOTS);

	// Control state of the reader.
	logic [1:0]  phase_q;
	logic [1:0]  hbc_q;
	logic        pend_s1;
	logic        clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	// Payload state.
	logic [15:0] id_q;
	logic [31:0] len_q;
	logic [31:0] rem_q;
	logic        pend_inr_s1;

	// Table RAM ports.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// Handshake and queue.
	logic                accept;
	logic                pop;
	logic [QUEUE_CW-1:0] level;
	msd_result_t         head;
	msd_push_t           push_a;
	msd_push_t           push_b;

	// State as seen after the pending lookup has resolved.
	logic [1:0]  eff_phase;
	logic [31:0] eff_rem;

	// Next state.
	logic [1:0]  phase_d;
	logic [1:0]  hbc_d;
	logic [15:0] id_d;
	logic [31:0] len_d;
	logic [31:0] rem_d;
	logic        slot_inr;
	logic        id_inr;

	msd_entry_t rd_entry;

	assign accept = stream.valid && stream.ready;
	assign pop    = result.valid && result.ready;

	// Ready needs room for both the lookup result and this transaction's one.
	assign stream.ready = !clr_busy_q && (level <= QUEUE_CW'(QUEUE_DEPTH - 2));

	assign slot_inr = {7'd0, stream.table_slot} < 17'(TABLE_SLOTS);
	assign id_inr   = {1'b0, stream.data_byte, id_q[7:0]} < 17'(TABLE_SLOTS);
	assign rd_entry = msd_entry_t'(ram_rdata);

	// Resolve the lookup issued in the previous cycle.
	always_comb begin
		eff_phase = phase_q;
		eff_rem   = rem_q;
		push_a    = '0;
		if (pend_s1) begin
			push_a.valid            = 1'b1;
			push_a.item.message_id  = id_q;
			if (!pend_inr_s1 || !rd_entry.known) begin
				push_a.item.result_kind     = RK_ERROR;
				push_a.item.last_of_message = 1'b1;
				eff_phase                   = PH_ID;
			end else if (rd_entry.var_len) begin
				push_a.valid = 1'b0;
				eff_phase    = PH_LEN;
			end else begin
				push_a.item.result_kind     = RK_HEADER;
				push_a.item.body_length     = {16'd0, rd_entry.len};
				push_a.item.last_of_message = (rd_entry.len == 16'd0);
				eff_phase = (rd_entry.len == 16'd0) ? PH_ID : PH_BODY;
				eff_rem   = {16'd0, rd_entry.len};
			end
		end
	end

	// Process the transaction accepted in this cycle against the resolved state.
	always_comb begin
		logic [15:0] len16;
		logic [31:0] len32;
		logic [31:0] rem_dec;
		len16   = {stream.data_byte, len_q[7:0]};
		len32   = {stream.data_byte, len_q[23:0]};
		rem_dec = eff_rem - 32'd1;

		phase_d = eff_phase;
		hbc_d   = hbc_q;
		id_d    = id_q;
		len_d   = len_q;
		rem_d   = eff_rem;
		ram_re  = 1'b0;
		push_b  = '0;
		push_b.item.message_id = id_q;

		if (accept && stream.kind == KIND_BYTE) begin
			case (eff_phase)
				PH_ID: begin
					if (hbc_q == 2'd0) begin
						id_d[7:0] = stream.data_byte;
						hbc_d     = 2'd1;
					end else begin
						id_d   = {stream.data_byte, id_q[7:0]};
						hbc_d  = 2'd0;
						ram_re = 1'b1;
					end
				end
				PH_LEN: begin
					if (hbc_q == 2'd0) begin
						len_d = {24'd0, stream.data_byte};
						hbc_d = 2'd1;
					end else begin
						hbc_d = 2'd0;
						len_d = {16'd0, len16};
						if (len16 == LEN_ESCAPE) begin
							phase_d = PH_EXT;
						end else begin
							push_b.valid                = 1'b1;
							push_b.item.result_kind     = RK_HEADER;
							push_b.item.body_length     = {16'd0, len16};
							push_b.item.last_of_message = (len16 == 16'd0);
							phase_d = (len16 == 16'd0) ? PH_ID : PH_BODY;
							rem_d   = {16'd0, len16};
						end
					end
				end
				PH_EXT: begin
					case (hbc_q)
						2'd0: len_d = {24'd0, stream.data_byte};
						2'd1: len_d[15:8] = stream.data_byte;
						2'd2: len_d[23:16] = stream.data_byte;
						default: len_d = len32;
					endcase
					if (hbc_q == 2'd3) begin
						hbc_d                       = 2'd0;
						push_b.valid                = 1'b1;
						push_b.item.result_kind     = RK_HEADER;
						push_b.item.body_length     = len32;
						push_b.item.last_of_message = (len32 == 32'd0);
						phase_d = (len32 == 32'd0) ? PH_ID : PH_BODY;
						rem_d   = len32;
					end else begin
						hbc_d = hbc_q + 2'd1;
					end
				end
				default: begin
					rem_d                       = rem_dec;
					push_b.valid                = 1'b1;
					push_b.item.result_kind     = RK_BODY;
					push_b.item.body_byte       = stream.data_byte;
					push_b.item.last_of_message = (rem_dec == 32'd0);
					if (rem_dec == 32'd0) begin
						phase_d = PH_ID;
					end
				end
			endcase
		end
	end

	// Table RAM: the clearing pass owns the write port until it finishes.
	always_comb begin
		logic [16:0] slot_ext;
		logic [16:0] id_ext;
		slot_ext  = {7'd0, stream.table_slot};
		id_ext    = {1'b0, stream.data_byte, id_q[7:0]};
		ram_raddr = id_ext[AW-1:0];
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = accept && stream.kind == KIND_TABLE && slot_inr;
			ram_waddr = slot_ext[AW-1:0];
			ram_wdata = {stream.slot_known, stream.slot_length[16], stream.slot_length[15:0]};
		end
	end

	msd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ID;
			hbc_q      <= 2'd0;
			pend_s1    <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			phase_q <= phase_d;
			hbc_q   <= hbc_d;
			pend_s1 <= ram_re;
			if (clr_busy_q) begin
				if (clr_idx_q == AW'(TABLE_SLOTS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		id_q        <= id_d;
		len_q       <= len_d;
		rem_q       <= rem_d;
		pend_inr_s1 <= id_inr;
	end

	// Lookup result goes in ahead of the result of the byte taken alongside it.
	msd_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (push_a),
		.push_b (push_b),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	assign result.valid           = (level != '0);
	assign result.result_kind     = head.result_kind;
	assign result.message_id      = head.message_id;
	assign result.body_length     = head.body_length;
	assign result.body_byte       = head.body_byte;
	assign result.last_of_message = head.last_of_message;

`ifndef SYNTH
	// While a lookup is in flight the reader sits at the start of an id.
	a_pend_at_id: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (phase_q == PH_ID && hbc_q == 2'd0))
		else $error("lookup pending outside the id phase");
	// Two lookups cannot start in consecutive cycles.
	a_no_back_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !ram_re)
		else $error("lookup started while one is pending");
	// A body in progress always has bytes left to deliver.
	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY && !pend_s1) |-> rem_q != 32'd0)
		else $error("body phase with no bytes remaining");
	// No transaction is taken during the table clearing pass.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !accept && !ram_re)
		else $error("transaction taken during table clear");
`endif

endmodule
